// ===== design/dtw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dtw_pkg;
   localparam int MAX_LEN_DEF    = 64;
   localparam int MAX_DIMS_DEF   = 4;
   localparam int COMP_WIDTH_DEF = 16;
   localparam int COST_WIDTH_DEF = 48;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;
   localparam int DIMS_W     = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_DIMS_USED = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_EDGES  = 8'd1;

   localparam logic OP_FIRST  = 1'b0;
   localparam logic OP_SECOND = 1'b1;
endpackage
`default_nettype wire

// ===== design/dynamic_time_warping_distance_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Dynamic time warping distance. Load vectors with start (operation 0 for the
// first sequence, 1 for the second), one per cycle while busy is low. A
// second-sequence beat with last set runs the cost matrix: each cell steps
// through store read, per-dimension square lanes, lane sum and min-and-add,
// and the result strobes on rsp_valid after the last cell. An empty first
// sequence answers in the next cycle instead. Each result shows for exactly
// one cycle and cannot be stalled. Both sequences are emptied after each
// result. Costs are in units of 2^-16.
module dynamic_time_warping_distance_top
   import dtw_pkg::*;
#(
   parameter int MAX_LEN    = MAX_LEN_DEF,
   parameter int MAX_DIMS   = MAX_DIMS_DEF,
   parameter int COMP_WIDTH = COMP_WIDTH_DEF,
   parameter int COST_WIDTH = COST_WIDTH_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire                          req_operation,
   input  wire  signed [COMP_WIDTH-1:0] req_comp0,
   input  wire  signed [COMP_WIDTH-1:0] req_comp1,
   input  wire  signed [COMP_WIDTH-1:0] req_comp2,
   input  wire  signed [COMP_WIDTH-1:0] req_comp3,
   input  wire                          req_last,
   output logic                         rsp_valid,
   output logic [COST_WIDTH-1:0]        rsp_distance,
   output logic                         rsp_saturated,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [CSR_IDX_W-1:0]         csr_index,
   input  wire  [CSR_DATA_W-1:0]        csr_wdata
);
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LEN_W = IDX_W + 1;
   localparam int VEC_W = MAX_DIMS * COMP_WIDTH;
   localparam logic [COST_WIDTH-1:0] COST_MAX = {COST_WIDTH{1'b1}};

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_SQ   = 5'b00100,
      ST_SUM  = 5'b01000,
      ST_ACC  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [LEN_W-1:0]      len1_ff, len1_in, len2_ff, len2_in;
   logic [IDX_W-1:0]      i_ff, i_in, j_ff, j_in;
   logic [DIMS_W-1:0]     dims_ff;
   logic                  no_edges_ff;
   logic [COST_WIDTH-1:0] left_ff, diag_ff;
   logic                  rsp_valid_ff;
   logic [COST_WIDTH-1:0] rsp_distance_ff;
   logic                  rsp_saturated_ff;

   logic [VEC_W-1:0]      first_mem [MAX_LEN];
   logic [VEC_W-1:0]      second_mem [MAX_LEN];
   logic [COST_WIDTH-1:0] row_mem [MAX_LEN];
   logic [VEC_W-1:0]      rd_first_ff, rd_second_ff;
   logic [COST_WIDTH-1:0] rd_old_ff;

   logic                  accept;
   logic [VEC_W-1:0]      vec_in;
   logic signed [COMP_WIDTH-1:0] comps [4];
   logic [2*COMP_WIDTH:0] sq [MAX_DIMS];
   logic [MAX_DIMS-1:0]   lane_en;
   logic [DIMS_W-1:0]     dims_eff;
   logic [COST_WIDTH-1:0] local_cost;
   logic [COST_WIDTH-1:0] best, cell_v, base;
   logic [COST_WIDTH:0]   add_sum;
   logic                  last_j, last_i, wr_row;
   logic [LEN_W-1:0]      len1_m1, len2_m1;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_saturated = rsp_saturated_ff;

   assign comps[0] = req_comp0;
   assign comps[1] = req_comp1;
   assign comps[2] = req_comp2;
   assign comps[3] = req_comp3;

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         vec_in[d*COMP_WIDTH +: COMP_WIDTH] = comps[d];
      end
   end

   assign dims_eff = (dims_ff > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : dims_ff;
   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         lane_en[d] = (DIMS_W'(d) < dims_eff);
      end
   end

   genvar g;
   generate
      for (g = 0; g < MAX_DIMS; g++) begin : g_lane
         dtw_lane #(.COMP_WIDTH(COMP_WIDTH)) u_lane (
            .clock (clock),
            .a     (rd_first_ff[g*COMP_WIDTH +: COMP_WIDTH]),
            .b     (rd_second_ff[g*COMP_WIDTH +: COMP_WIDTH]),
            .sq_ff (sq[g])
         );
      end
   endgenerate

   dtw_merge #(
      .MAX_DIMS   (MAX_DIMS),
      .COMP_WIDTH (COMP_WIDTH),
      .COST_WIDTH (COST_WIDTH)
   ) u_merge (
      .clock   (clock),
      .sq      (sq),
      .lane_en (lane_en),
      .cost_ff (local_cost)
   );

   // storage
   always_ff @(posedge clock) begin
      if (accept && req_operation == OP_FIRST && len1_ff < LEN_W'(MAX_LEN)) begin
         first_mem[len1_ff[IDX_W-1:0]] <= vec_in;
      end
      if (accept && req_operation == OP_SECOND && len2_ff < LEN_W'(MAX_LEN)) begin
         second_mem[len2_ff[IDX_W-1:0]] <= vec_in;
      end
      if (wr_row) begin
         row_mem[j_ff] <= cell_v;
      end
      rd_first_ff  <= first_mem[i_ff];
      rd_second_ff <= second_mem[j_ff];
      rd_old_ff    <= row_mem[j_ff];
   end

   // cell update
   always_comb begin
      len1_m1 = len1_ff - LEN_W'(1);
      len2_m1 = len2_ff - LEN_W'(1);
      last_j  = (j_ff == len2_m1[IDX_W-1:0]);
      last_i  = (i_ff == len1_m1[IDX_W-1:0]);
      best = rd_old_ff;
      if (left_ff < best) best = left_ff;
      if (diag_ff < best) best = diag_ff;
      if (i_ff == '0) base = left_ff;
      else if (j_ff == '0) base = rd_old_ff;
      else base = best;
      add_sum = {1'b0, base} + {1'b0, local_cost};
      if (i_ff == '0 && j_ff == '0) begin
         cell_v = local_cost;
      end else if ((i_ff == '0 || j_ff == '0) && no_edges_ff) begin
         cell_v = COST_MAX;
      end else begin
         cell_v = add_sum[COST_WIDTH] ? COST_MAX : add_sum[COST_WIDTH-1:0];
      end
      wr_row = (state_ff == ST_ACC);
   end

   always_comb begin
      state_in = state_ff;
      len1_in  = len1_ff;
      len2_in  = len2_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_FIRST) begin
                  if (len1_ff < LEN_W'(MAX_LEN)) len1_in = len1_ff + LEN_W'(1);
               end else begin
                  if (len2_ff < LEN_W'(MAX_LEN)) len2_in = len2_ff + LEN_W'(1);
                  if (req_last) begin
                     i_in = '0;
                     j_in = '0;
                     if (len1_ff == '0) begin
                        len1_in = '0;
                        len2_in = '0;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
               end
            end
         end
         ST_READ: state_in = ST_SQ;
         ST_SQ:   state_in = ST_SUM;
         ST_SUM:  state_in = ST_ACC;
         ST_ACC: begin
            state_in = ST_READ;
            if (last_j) begin
               j_in = '0;
               i_in = i_ff + IDX_W'(1);
               if (last_i) begin
                  state_in = ST_IDLE;
                  len1_in  = '0;
                  len2_in  = '0;
               end
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len1_ff      <= '0;
         len2_ff      <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         dims_ff      <= DIMS_W'(1);
         no_edges_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len1_ff  <= len1_in;
         len2_ff  <= len2_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         if (csr_valid && csr_index == CSR_DIMS_USED) dims_ff <= csr_wdata[DIMS_W-1:0];
         if (csr_valid && csr_index == CSR_NO_EDGES) no_edges_ff <= csr_wdata[0];
         rsp_valid_ff <= (state_ff == ST_ACC && last_j && last_i) ||
                         (accept && req_operation == OP_SECOND && req_last &&
                          len1_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_ACC) begin
         diag_ff <= rd_old_ff;
         left_ff <= cell_v;
      end
      if (state_ff == ST_ACC && last_j && last_i) begin
         rsp_distance_ff  <= cell_v;
         rsp_saturated_ff <= (cell_v == COST_MAX);
      end else if (accept) begin
         rsp_distance_ff  <= '0;
         rsp_saturated_ff <= 1'b1;
      end
   end
endmodule
`default_nettype wire

// ===== design/dtw_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dtw_lane
   import dtw_pkg::*;
#(
   parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
   input  wire                            clock,
   input  wire  signed [COMP_WIDTH-1:0]   a,
   input  wire  signed [COMP_WIDTH-1:0]   b,
   output logic        [2*COMP_WIDTH:0]   sq_ff
);
   localparam int DW = COMP_WIDTH + 1;

   logic signed [DW-1:0]         diff;
   logic        [DW-1:0]         mag;
   logic        [2*DW-1:0]       prod;

   always_comb begin
      diff = DW'(a) - DW'(b);
      mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
      prod = {{DW{1'b0}}, mag} * {{DW{1'b0}}, mag};
   end

   always_ff @(posedge clock) begin
      sq_ff <= prod[2*COMP_WIDTH:0];
   end
endmodule
`default_nettype wire

// ===== design/dtw_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dtw_merge
   import dtw_pkg::*;
#(
   parameter int MAX_DIMS   = MAX_DIMS_DEF,
   parameter int COMP_WIDTH = COMP_WIDTH_DEF,
   parameter int COST_WIDTH = COST_WIDTH_DEF
) (
   input  wire                      clock,
   input  wire  [2*COMP_WIDTH:0]    sq [MAX_DIMS],
   input  wire  [MAX_DIMS-1:0]      lane_en,
   output logic [COST_WIDTH-1:0]    cost_ff
);
   localparam int SQ_W  = 2 * COMP_WIDTH + 1;
   localparam int SUM_W = SQ_W + 2;
   localparam int CMP_W = (SUM_W > COST_WIDTH) ? SUM_W : COST_WIDTH;

   logic [SUM_W-1:0] sum;
   logic [CMP_W-1:0] sum_ext;
   logic [CMP_W-1:0] max_ext;

   always_comb begin
      sum = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (lane_en[d]) begin
            sum = sum + SUM_W'(sq[d]);
         end
      end
      sum_ext = CMP_W'(sum);
      max_ext = CMP_W'({COST_WIDTH{1'b1}});
   end

   always_ff @(posedge clock) begin
      cost_ff <= (sum_ext > max_ext) ? {COST_WIDTH{1'b1}} : sum_ext[COST_WIDTH-1:0];
   end
endmodule
`default_nettype wire

// ===== design/dtw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dtw_checker
   import dtw_pkg::*;
#(
   parameter int COST_WIDTH = COST_WIDTH_DEF
) (
   input wire                  clock,
   input wire                  reset,
   input wire                  start,
   input wire                  busy,
   input wire                  rsp_valid,
   input wire [COST_WIDTH-1:0] rsp_distance,
   input wire                  rsp_saturated
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("busy or strobe after reset");
   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(start && !busy) |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start))
      else $error("result without work");
   a_max_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_distance == {COST_WIDTH{1'b1}} |-> rsp_saturated)
      else $error("saturated distance without flag");
endmodule

bind dynamic_time_warping_distance_top dtw_checker #(.COST_WIDTH(COST_WIDTH)) u_dtw_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_distance  (rsp_distance),
   .rsp_saturated (rsp_saturated)
);
`default_nettype wire

// ===== tb/tb_dynamic_time_warping_distance_top.sv =====
`timescale 1ns / 1ps
module tb_dynamic_time_warping_distance_top;
   import dtw_pkg::*;

   localparam int LEN  = MAX_LEN_DEF;
   localparam int DIMS = MAX_DIMS_DEF;
   localparam longint unsigned COST_MAX = 64'h0000_FFFF_FFFF_FFFF;

   typedef logic signed [COMP_WIDTH_DEF-1:0] comp_type;
   typedef comp_type vec_type [DIMS];

   typedef struct {
      logic [COST_WIDTH_DEF-1:0] distance;
      logic                      saturated;
   } warp_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_operation = 1'b0;
   comp_type req_comp0 = '0, req_comp1 = '0, req_comp2 = '0, req_comp3 = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic [COST_WIDTH_DEF-1:0] rsp_distance;
   logic rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   dynamic_time_warping_distance_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_comp0(req_comp0), .req_comp1(req_comp1),
      .req_comp2(req_comp2), .req_comp3(req_comp3), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_distance(rsp_distance), .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   vec_type first_seq [LEN];
   vec_type second_seq [LEN];
   int first_len = 0;
   int second_len = 0;
   longint unsigned cost_row [LEN];
   int dims_cfg = 1;
   bit no_edges_cfg = 1'b0;
   warp_result_type expected_costs [$];
   bit failed = 1'b0;
   bit calm = 1'b0;
   int beats_sent = 0;

   function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > COST_MAX) ? COST_MAX : s;
   endfunction

   function automatic longint unsigned warp_distance();
      longint unsigned c, old, v, m, diag, mag;
      longint diff;
      int nd;
      nd = (dims_cfg > DIMS) ? DIMS : dims_cfg;
      diag = 0;
      for (int i = 0; i < first_len; i++) begin
         for (int j = 0; j < second_len; j++) begin
            c = 0;
            for (int d = 0; d < nd; d++) begin
               diff = longint'(first_seq[i][d]) - longint'(second_seq[j][d]);
               mag = (diff < 0) ? -diff : diff;
               c = sat_sum(c, mag * mag);
            end
            old = cost_row[j];
            if (i == 0 && j == 0) begin
               v = c;
            end else if (i == 0) begin
               v = no_edges_cfg ? COST_MAX : sat_sum(cost_row[j-1], c);
            end else if (j == 0) begin
               v = no_edges_cfg ? COST_MAX : sat_sum(old, c);
            end else begin
               m = old;
               if (cost_row[j-1] < m) m = cost_row[j-1];
               if (diag < m) m = diag;
               v = sat_sum(m, c);
            end
            diag = old;
            cost_row[j] = v;
         end
      end
      return cost_row[second_len-1];
   endfunction

   function automatic void load_beat(logic op, vec_type v, logic last);
      warp_result_type r;
      longint unsigned warp_cost;
      if (op == OP_FIRST) begin
         if (first_len < LEN) begin
            first_seq[first_len] = v;
            first_len++;
         end
         return;
      end
      if (second_len < LEN) begin
         second_seq[second_len] = v;
         second_len++;
      end
      if (!last) return;
      if (first_len == 0) begin
         r.distance = '0;
         r.saturated = 1'b1;
      end else begin
         warp_cost = warp_distance();
         r.distance = warp_cost[COST_WIDTH_DEF-1:0];
         r.saturated = (warp_cost == COST_MAX);
      end
      expected_costs.push_back(r);
      first_len = 0;
      second_len = 0;
   endfunction

   always @(posedge clock) begin
      warp_result_type e;
      if (!reset && rsp_valid) begin
         if (expected_costs.size() == 0) begin
            $error("unexpected result beat: distance %0h", rsp_distance);
            failed = 1'b1;
         end else begin
            e = expected_costs.pop_front();
            if (rsp_distance !== e.distance) begin
               $error("distance: expected %0h actual %0h", e.distance, rsp_distance);
               failed = 1'b1;
            end
            if (rsp_saturated !== e.saturated) begin
               $error("saturated: expected %0b actual %0b", e.saturated, rsp_saturated);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic send_vec(logic op, vec_type v, logic last);
      @(negedge clock);
      if (!calm && $urandom_range(99) < 15) begin
         start = 1'b0;
         repeat ($urandom_range(4)) @(negedge clock);
      end
      req_operation = op;
      req_comp0 = v[0];
      req_comp1 = v[1];
      req_comp2 = v[2];
      req_comp3 = v[3];
      req_last = last;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      load_beat(op, v, last);
      beats_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (expected_costs.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_index = idx;
      csr_wdata = data;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_DIMS_USED) dims_cfg = data[2:0];
      else if (idx == CSR_NO_EDGES) no_edges_cfg = data[0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic comp_type rand_comp();
      case ($urandom_range(3))
         0: return comp_type'($urandom);
         1: return comp_type'($signed($urandom_range(512)) - 256);
         2: return $urandom_range(1) ? comp_type'(16'h7fff) : comp_type'(16'h8000);
         default: return comp_type'($urandom_range(65535));
      endcase
   endfunction

   function automatic vec_type rand_vec();
      vec_type v;
      for (int d = 0; d < DIMS; d++) v[d] = rand_comp();
      return v;
   endfunction

   function automatic vec_type fill_vec(comp_type x);
      vec_type v;
      for (int d = 0; d < DIMS; d++) v[d] = x;
      return v;
   endfunction

   task automatic send_pair(int n1, int n2);
      for (int i = 0; i < n1; i++) send_vec(OP_FIRST, rand_vec(), $urandom_range(7) == 0);
      for (int i = 0; i < n2; i++) send_vec(OP_SECOND, rand_vec(), i == n2 - 1);
   endtask

   task automatic test_basic();
      send_pair(3, 4);
      send_pair(1, 1);
      drain();
   endtask

   task automatic test_extremes();
      write_csr(CSR_DIMS_USED, 8'd4);
      send_vec(OP_FIRST, fill_vec(16'h7fff), 1'b0);
      send_vec(OP_FIRST, fill_vec(16'h8000), 1'b0);
      send_vec(OP_SECOND, fill_vec(16'h8000), 1'b0);
      send_vec(OP_SECOND, fill_vec(16'h7fff), 1'b0);
      send_vec(OP_SECOND, fill_vec(16'h0000), 1'b1);
      drain();
   endtask

   task automatic test_empty_and_ignored_last();
      send_vec(OP_SECOND, rand_vec(), 1'b1);
      send_vec(OP_FIRST, rand_vec(), 1'b1);
      send_vec(OP_SECOND, rand_vec(), 1'b1);
      drain();
   endtask

   task automatic test_no_edges();
      write_csr(CSR_NO_EDGES, 8'd1);
      send_pair(1, 3);
      send_pair(3, 1);
      send_pair(1, 1);
      send_pair(3, 3);
      drain();
      write_csr(CSR_NO_EDGES, 8'd0);
   endtask

   task automatic test_dims_range();
      write_csr(CSR_DIMS_USED, 8'd0);
      send_pair(2, 2);
      drain();
      write_csr(CSR_DIMS_USED, 8'd7);
      send_pair(2, 2);
      drain();
   endtask

   task automatic test_full_stores();
      calm = 1'b1;
      write_csr(CSR_DIMS_USED, 8'd2);
      send_pair(LEN + 2, LEN + 2);
      drain();
      calm = 1'b0;
   endtask

   task automatic test_random();
      int n1, n2, k;
      k = 0;
      while (beats_sent < 1350) begin
         calm = (beats_sent > 500 && beats_sent < 800);
         if (k % 15 == 0) begin
            drain();
            write_csr(CSR_DIMS_USED, 8'($urandom_range(255)));
            write_csr(CSR_NO_EDGES, ($urandom_range(3) == 0) ? 8'($urandom) : 8'd0);
         end
         if ($urandom_range(9) == 0) begin
            for (int i = 0; i < $urandom_range(3); i++)
               send_vec(1'($urandom_range(1)), rand_vec(), 1'b0);
         end
         n1 = ($urandom_range(19) == 0) ? 0 : $urandom_range(8, 1);
         n2 = $urandom_range(8, 1);
         if ($urandom_range(29) == 0) begin
            n1 = $urandom_range(40, 10);
            n2 = $urandom_range(40, 10);
         end
         send_pair(n1, n2);
         k++;
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_basic();
      test_extremes();
      test_empty_and_ignored_last();
      test_no_edges();
      test_dims_range();
      test_full_stores();
      test_random();
      if (!failed && expected_costs.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("simulation failed");
      $finish;
   end
endmodule

// ===== files.f =====
design/dtw_pkg.sv
design/dtw_lane.sv
design/dtw_merge.sv
design/dynamic_time_warping_distance_top.sv
design/dtw_checker.sv
tb/tb_dynamic_time_warping_distance_top.sv
